FILE: hdl/smr_pkg.sv
// ----------------------------------------------------------------------------
// smr_pkg
// Shared constants, types and word conversion helpers for the signed scaled
// multiply-divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smr_pkg;

  // width of the external fields
  localparam int unsigned FIELD_BITS = 32;

  // width of the internal arithmetic word
  localparam int unsigned WORD_BITS = 32;

  // step counter wide enough to hold WORD_BITS itself
  localparam int unsigned CNT_W = $clog2(WORD_BITS + 1);

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  // status of one serial unit
  typedef struct packed {
    logic busy;
    logic done;
  } smr_stat_t;

  // sign-extend a field and reduce it modulo the word width
  function automatic word_t to_word(input field_t f);
    to_word = WORD_BITS'(signed'(f));
  endfunction

  // sign-extend a word and cut it to the field width
  function automatic field_t to_field(input word_t w);
    to_field = FIELD_BITS'(signed'(w));
  endfunction

  // magnitude of a signed word as an unsigned word
  function automatic word_t mag(input word_t w);
    mag = w[WORD_BITS-1] ? (~w + word_t'(1)) : w;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/smr_if.sv
// ----------------------------------------------------------------------------
// smr_in_if / smr_out_if
// Valid/ready channels carrying the operand beat and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface smr_in_if;
  import smr_pkg::*;

  logic   valid;
  logic   ready;
  field_t multiplicand;
  field_t multiplier;
  field_t divisor;

  modport source (output valid, output multiplicand, output multiplier,
                  output divisor, input ready);
  modport sink   (input valid, input multiplicand, input multiplier,
                  input divisor, output ready);
endinterface

interface smr_out_if;
  import smr_pkg::*;

  logic   valid;
  logic   ready;
  field_t quotient;
  field_t remainder;

  modport source (output valid, output quotient, output remainder, input ready);
  modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

`default_nettype wire

FILE: hdl/smr_divider.sv
// ----------------------------------------------------------------------------
// smr_divider
// Restoring bit-serial divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_divider (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  smr_pkg::word_t      dividend_i,
  input  smr_pkg::word_t      divisor_i,
  output smr_pkg::smr_stat_t  stat_o,
  output smr_pkg::word_t      quot_o,
  output smr_pkg::word_t      rem_o
);
  import smr_pkg::*;

  word_t dvd_q, dvd_d;
  word_t rem_q, rem_d;
  cnt_t  cnt_q, cnt_d;
  logic  busy_q, busy_d;
  logic  done_q, done_d;
  word_t trial;
  logic  fits;

  // one restoring step: bring down the next dividend bit and try the subtract
  always_comb begin
    trial = {rem_q[WORD_BITS-2:0], dvd_q[WORD_BITS-1]};
    fits  = (trial >= divisor_i);
    rem_d = fits ? (trial - divisor_i) : trial;
    dvd_d = {dvd_q[WORD_BITS-2:0], fits};
  end

  // step control
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = cnt_t'(WORD_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q - cnt_t'(1);
      if (cnt_q == cnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = dvd_q;
  assign rem_o       = rem_q;

endmodule

`default_nettype wire

FILE: hdl/smr_accum.sv
// ----------------------------------------------------------------------------
// smr_accum
// Shift-add pass over the bits of |a|, one bit per cycle, accumulating
// partial quotient and remainder with carry correction against |c|.
// ----------------------------------------------------------------------------
`default_nettype none

module smr_accum (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  smr_pkg::word_t      mcand_i,
  input  smr_pkg::word_t      part_q_i,
  input  smr_pkg::word_t      part_r_i,
  input  smr_pkg::word_t      divisor_i,
  output smr_pkg::smr_stat_t  stat_o,
  output smr_pkg::word_t      quot_o,
  output smr_pkg::word_t      rem_o
);
  import smr_pkg::*;

  word_t a_q;
  word_t q_q, q_d;
  word_t r_q, r_d;
  word_t qn_q, qn_d;
  word_t rn_q, rn_d;
  cnt_t  cnt_q, cnt_d;
  logic  busy_q, busy_d;
  logic  done_q, done_d;
  word_t sum;
  logic  sum_carry;
  word_t rn_dbl;
  logic  rn_carry;

  // add the partial pair when the current bit of a is set
  always_comb begin
    sum       = r_q + rn_q;
    sum_carry = (sum >= divisor_i);
    if (a_q[0]) begin
      q_d = q_q + qn_q + word_t'(sum_carry);
      r_d = sum_carry ? (sum - divisor_i) : sum;
    end else begin
      q_d = q_q;
      r_d = r_q;
    end
  end

  // double the partial pair, folding a full divisor back into the quotient
  always_comb begin
    rn_dbl   = {rn_q[WORD_BITS-2:0], 1'b0};
    rn_carry = (rn_dbl >= divisor_i);
    rn_d     = rn_carry ? (rn_dbl - divisor_i) : rn_dbl;
    qn_d     = {qn_q[WORD_BITS-2:0], rn_carry};
  end

  // step control
  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      cnt_d  = cnt_t'(WORD_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      cnt_d = cnt_q - cnt_t'(1);
      if (cnt_q == cnt_t'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath registers, a shifts right to expose the next bit
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= mcand_i;
      q_q  <= '0;
      r_q  <= '0;
      qn_q <= part_q_i;
      rn_q <= part_r_i;
    end else if (busy_q) begin
      a_q  <= {1'b0, a_q[WORD_BITS-1:1]};
      q_q  <= q_d;
      r_q  <= r_d;
      qn_q <= qn_d;
      rn_q <= rn_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = q_q;
  assign rem_o       = r_q;

endmodule

`default_nettype wire

FILE: hdl/signed_muldiv_remainder_unit.sv
// ----------------------------------------------------------------------------
// signed_muldiv_remainder_unit
// Quotient and remainder of a*b/c without a double-width product.
//
// in_i carries one operand beat (multiplicand a, multiplier b, divisor c);
// out_o carries one result beat (quotient, remainder) per operand beat.
// A divisor of zero is used as one. The quotient is truncated toward zero
// and wraps modulo the word width; the remainder carries the sign of a*b.
// Magnitudes and signs are latched on the operand beat, together with the
// registered divider start; the bit-serial divider then splits |b| by |c|,
// its done pulse starts the shift-add pass over |a|, the sequencer sees the
// pass end and enters its done state, and the signs are applied as the
// result is loaded into the output register.
// One item is in flight at a time; in_i.ready is high only while idle and
// rises as the result is loaded, so a new operand beat waits until the
// previous result has been loaded into the output register. The result sits
// in an output register: a new operand beat is taken while it waits, and a
// stalled receiver only holds back the next result at its final step. Reset
// clears all control state and drops out_o.valid; no result is pending
// afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_muldiv_remainder_unit (
  input  wire        clk_i,
  input  wire        rst_ni,
  smr_in_if.sink     in_i,
  smr_out_if.source  out_o
);
  import smr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       div_start_q, div_start_d;
  logic       qneg_q, rneg_q;
  word_t      a_mag_q, b_mag_q, c_mag_q;
  logic       out_valid_q, out_valid_d;
  field_t     quotient_q, remainder_q;

  word_t      a_w, b_w, c_w, c_fix;
  logic       in_beat, out_load;

  smr_stat_t  div_stat, acc_stat;
  word_t      div_quot, div_rem, acc_quot, acc_rem;
  word_t      q_signed, r_signed;

  assign in_beat = in_i.valid && in_i.ready;

  // operands in word form, zero divisor replaced by one
  always_comb begin
    a_w   = to_word(in_i.multiplicand);
    b_w   = to_word(in_i.multiplier);
    c_w   = to_word(in_i.divisor);
    c_fix = (c_w == '0) ? word_t'(1) : c_w;
  end

  // latch magnitudes and signs on the operand beat
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      a_mag_q <= mag(a_w);
      b_mag_q <= mag(b_w);
      c_mag_q <= mag(c_fix);
      rneg_q  <= a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1];
      qneg_q  <= a_w[WORD_BITS-1] ^ b_w[WORD_BITS-1] ^ c_fix[WORD_BITS-1];
    end
  end

  // split |b| into |b|/|c| and |b|%|c|
  smr_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_q),
    .dividend_i (b_mag_q),
    .divisor_i  (c_mag_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // shift-add over the bits of |a|
  smr_accum u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_stat.done),
    .mcand_i   (a_mag_q),
    .part_q_i  (div_quot),
    .part_r_i  (div_rem),
    .divisor_i (c_mag_q),
    .stat_o    (acc_stat),
    .quot_o    (acc_quot),
    .rem_o     (acc_rem)
  );

  // apply signs to the accumulated result
  always_comb begin
    q_signed = qneg_q ? (~acc_quot + word_t'(1)) : acc_quot;
    r_signed = rneg_q ? (~acc_rem + word_t'(1)) : acc_rem;
  end

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  // sequencer
  always_comb begin
    state_d     = state_q;
    div_start_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d     = ST_DIV;
          div_start_d = 1'b1;
        end
      end
      ST_DIV: begin
        if (div_stat.done) state_d = ST_MUL;
      end
      ST_MUL: begin
        if (acc_stat.done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_start_q <= div_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      quotient_q  <= to_field(q_signed);
      remainder_q <= to_field(r_signed);
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.quotient  = quotient_q;
  assign out_o.remainder = remainder_q;

`ifndef NO_ASSERTIONS
  // divider and accumulator never run together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_stat.busy && acc_stat.busy))
    else $error("divider and accumulator busy at once");

  // a new operand beat only arrives with both serial units idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> (!div_stat.busy && !acc_stat.busy && !div_start_q))
    else $error("operand beat taken while a serial unit is active");

  // accumulator finishes only while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_stat.done |-> (state_q == ST_MUL))
    else $error("accumulator done outside the multiply phase");

  // a zero divisor is replaced by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && (c_w == '0)) |=> (c_mag_q == word_t'(1)))
    else $error("zero divisor not replaced by one");
`endif

endmodule

`default_nettype wire
